// ===== hw/rtl/bmpd_pkg.sv =====
// package for the bitmap deframer: header positions, item types
`default_nettype none
package bmpd_pkg;

  localparam int unsigned PosW = 32;

  localparam logic [PosW-1:0] HDR_OFFSET_POS = PosW'(10);
  localparam logic [PosW-1:0] HDR_WIDTH_POS  = PosW'(18);
  localparam logic [PosW-1:0] HDR_HEIGHT_POS = PosW'(22);
  localparam logic [PosW-1:0] HDR_END_POS    = PosW'(26);
  localparam logic [PosW-1:0] HDR_WORD_LEN   = PosW'(4);
  localparam logic [1:0]      HDR_LANE_BIAS  = 2'd2;
  localparam logic [1:0]      PIX_BYTE_LAST  = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       file_start;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;
    logic       row_last;
    logic       image_last;
  } pix_item_t;

  function automatic logic [PosW-1:0] put_le_byte(input logic [PosW-1:0] word,
                                                  input logic [1:0] lane,
                                                  input logic [7:0] b);
    logic [PosW-1:0] res;
    res = word;
    case (lane)
      2'd0:    res[7:0]   = b;
      2'd1:    res[15:8]  = b;
      2'd2:    res[23:16] = b;
      default: res[31:24] = b;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bmpd_if.sv =====
// stream interfaces for file bytes and pixels
`default_nettype none
interface bmpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       file_start;

  modport source (output valid, output byte_value, output file_start, input ready);
  modport sink   (input valid, input byte_value, input file_start, output ready);
endinterface

interface bmpd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_first;
  logic [7:0] chan_second;
  logic [7:0] chan_third;
  logic       row_last;
  logic       image_last;

  modport source (output valid, output chan_first, output chan_second, output chan_third,
                  output row_last, output image_last, input ready);
  modport sink   (input valid, input chan_first, input chan_second, input chan_third,
                  input row_last, input image_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bmpd_in_reg.sv =====
// input register for the byte stream
`default_nettype none
module bmpd_in_reg
  import bmpd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  bmpd_byte_if.sink   bytes,
  output byte_item_t  item,
  output logic        item_valid,
  input  wire logic   item_take
);

  assign bytes.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (bytes.ready) begin
      item_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.byte_value <= bytes.byte_value;
      item.file_start <= bytes.file_start;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bmpd_core.sv =====
// header capture, pixel grouping, row padding and result register
`default_nettype none
module bmpd_core
  import bmpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire byte_item_t  item,
  input  wire logic        item_valid,
  output logic             item_take,
  bmpd_pix_if.source       pixels
);

  logic [PosW-1:0] byte_position, byte_position_next;
  logic [PosW-1:0] pixel_data_offset, pixel_data_offset_next;
  logic [PosW-1:0] image_width, image_width_next;
  logic [PosW-1:0] image_height, image_height_next;
  logic [1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [7:0]      held_bytes [2];
  logic [7:0]      held_bytes_next [2];
  logic [PosW-1:0] column_count, column_count_next;
  logic [PosW-1:0] row_count, row_count_next;
  logic [1:0]      pad_left, pad_left_next;
  logic            image_done, image_done_next;

  logic            out_valid;
  pix_item_t       out_item;
  logic            produced;
  pix_item_t       res;

  logic [PosW-1:0] pos, off, wid, hgt, col, row;
  logic [1:0]      bip, pad;
  logic            done;
  logic [1:0]      lane;
  logic [PosW-1:0] col_inc, row_inc;

  assign item_take = item_valid && (!out_valid || pixels.ready);

  always_comb begin
    // a file start clears the position, header and counter state before the byte is handled
    pos  = item.file_start ? '0 : byte_position;
    off  = item.file_start ? '0 : pixel_data_offset;
    wid  = item.file_start ? '0 : image_width;
    hgt  = item.file_start ? '0 : image_height;
    col  = item.file_start ? '0 : column_count;
    row  = item.file_start ? '0 : row_count;
    bip  = item.file_start ? 2'd0 : byte_in_pixel;
    pad  = item.file_start ? 2'd0 : pad_left;
    done = item.file_start ? 1'b0 : image_done;
    lane = pos[1:0] - HDR_LANE_BIAS;
    col_inc = col + PosW'(1);
    row_inc = row + PosW'(1);

    pixel_data_offset_next = off;
    image_width_next       = wid;
    image_height_next      = hgt;
    column_count_next      = col;
    row_count_next         = row;
    byte_in_pixel_next     = bip;
    pad_left_next          = pad;
    image_done_next        = done;
    held_bytes_next[0]     = item.file_start ? 8'd0 : held_bytes[0];
    held_bytes_next[1]     = item.file_start ? 8'd0 : held_bytes[1];
    produced               = 1'b0;
    res.chan_first         = held_bytes_next[0];
    res.chan_second        = held_bytes_next[1];
    res.chan_third         = item.byte_value;
    res.row_last           = 1'b0;
    res.image_last         = 1'b0;

    if (pos >= HDR_OFFSET_POS && pos < HDR_OFFSET_POS + HDR_WORD_LEN) begin
      pixel_data_offset_next = put_le_byte(off, lane, item.byte_value);
    end else if (pos >= HDR_WIDTH_POS && pos < HDR_WIDTH_POS + HDR_WORD_LEN) begin
      image_width_next = put_le_byte(wid, lane, item.byte_value);
    end else if (pos >= HDR_HEIGHT_POS && pos < HDR_HEIGHT_POS + HDR_WORD_LEN) begin
      image_height_next = put_le_byte(hgt, lane, item.byte_value);
    end else if (pos >= HDR_END_POS && pos >= off && !done && wid != '0 && hgt != '0) begin
      if (pad != 2'd0) begin
        pad_left_next = pad - 2'd1;
      end else if (bip != PIX_BYTE_LAST) begin
        held_bytes_next[bip[0]] = item.byte_value;
        byte_in_pixel_next      = bip + 2'd1;
      end else begin
        byte_in_pixel_next = 2'd0;
        column_count_next  = col_inc;
        produced           = 1'b1;
        if (col_inc == wid) begin
          res.row_last      = 1'b1;
          column_count_next = '0;
          row_count_next    = row_inc;
          if (row_inc == hgt) begin
            res.image_last  = 1'b1;
            image_done_next = 1'b1;
          end else begin
            pad_left_next = wid[1:0];
          end
        end
      end
    end

    // saturating file position
    byte_position_next = (pos != '1) ? pos + PosW'(1) : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      pixel_data_offset <= '0;
      image_width       <= '0;
      image_height      <= '0;
      byte_in_pixel     <= 2'd0;
      held_bytes[0]     <= 8'd0;
      held_bytes[1]     <= 8'd0;
      column_count      <= '0;
      row_count         <= '0;
      pad_left          <= 2'd0;
      image_done        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (item_take) begin
        byte_position     <= byte_position_next;
        pixel_data_offset <= pixel_data_offset_next;
        image_width       <= image_width_next;
        image_height      <= image_height_next;
        byte_in_pixel     <= byte_in_pixel_next;
        held_bytes[0]     <= held_bytes_next[0];
        held_bytes[1]     <= held_bytes_next[1];
        column_count      <= column_count_next;
        row_count         <= row_count_next;
        pad_left          <= pad_left_next;
        image_done        <= image_done_next;
        out_valid         <= produced;
      end else if (pixels.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && produced) begin
      out_item <= res;
    end
  end

  assign pixels.valid       = out_valid;
  assign pixels.chan_first  = out_item.chan_first;
  assign pixels.chan_second = out_item.chan_second;
  assign pixels.chan_third  = out_item.chan_third;
  assign pixels.row_last    = out_item.row_last;
  assign pixels.image_last  = out_item.image_last;

  a_new_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(item_valid))
    else $error("result appeared without a byte in the input register");

  a_pad_between_pixels: assert property (@(posedge clk) disable iff (rst)
    (pad_left != 2'd0) |-> (byte_in_pixel == 2'd0))
    else $error("row padding while a pixel is partly held");

  a_pixel_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_in_pixel != 2'd3)
    else $error("byte count within pixel out of range");

  a_image_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.image_last) |-> out_item.row_last)
    else $error("last pixel of image not marked as last of row");

  a_done_no_pad: assert property (@(posedge clk) disable iff (rst)
    image_done |-> (pad_left == 2'd0 && column_count == '0))
    else $error("padding or column count left after image end");

endmodule
`default_nettype wire

// ===== hw/rtl/bmp24_pixel_deframer_top.sv =====
// 24-bit bitmap deframer: one file byte per transfer in, one pixel per transfer out
// output: a pixel is offered from the result register after its third byte has passed the input register
// throughput: one byte per cycle unless the pixel output stalls, set by the single state update
//   between the input register and the result register; at most one pixel per three bytes
// reset: rst is synchronous and clears position, header words, counters and valids;
//   a byte marked file_start clears position, header words and counters before it is handled
`default_nettype none
module bmp24_pixel_deframer_top
  import bmpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  bmpd_byte_if.sink  bytes,
  bmpd_pix_if.source pixels
);

  byte_item_t item;
  logic       item_valid;
  logic       item_take;

  bmpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  bmpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .pixels     (pixels)
  );

endmodule
`default_nettype wire

// ===== verif/bmpd_checker.sv =====
// pixel predictor and checker for the bitmap deframer, fed from both stream channels
`timescale 1ns / 100ps
module bmpd_checker
  import bmpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bmpd_byte_if        bytes,
  bmpd_pix_if         pixels,
  output int unsigned fail_count,
  output int unsigned pixels_due
);

  localparam int unsigned MaxReports = 10;

  logic [PosW-1:0] file_pos;
  logic [PosW-1:0] pix_start;
  logic [PosW-1:0] img_w;
  logic [PosW-1:0] img_h;
  logic [PosW-1:0] col_cnt;
  logic [PosW-1:0] row_cnt;
  logic [1:0]      pix_phase;
  logic [1:0]      pad_cnt;
  logic [7:0]      pix_hold [2];
  logic            img_done;

  pix_item_t pixel_queue [$];

  task automatic clear_frame();
    file_pos    = '0;
    pix_start   = '0;
    img_w       = '0;
    img_h       = '0;
    col_cnt     = '0;
    row_cnt     = '0;
    pix_phase   = '0;
    pad_cnt     = '0;
    pix_hold[0] = '0;
    pix_hold[1] = '0;
    img_done    = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic mark);
    pix_item_t px;
    if (mark) clear_frame();
    if (file_pos >= HDR_OFFSET_POS && file_pos < HDR_OFFSET_POS + HDR_WORD_LEN) begin
      pix_start[8*(file_pos - HDR_OFFSET_POS) +: 8] = b;
    end else if (file_pos >= HDR_WIDTH_POS && file_pos < HDR_WIDTH_POS + HDR_WORD_LEN) begin
      img_w[8*(file_pos - HDR_WIDTH_POS) +: 8] = b;
    end else if (file_pos >= HDR_HEIGHT_POS && file_pos < HDR_HEIGHT_POS + HDR_WORD_LEN) begin
      img_h[8*(file_pos - HDR_HEIGHT_POS) +: 8] = b;
    end else if (file_pos >= HDR_END_POS && file_pos >= pix_start && !img_done &&
                 img_w != '0 && img_h != '0) begin
      if (pad_cnt != '0) begin
        pad_cnt--;
      end else if (pix_phase < PIX_BYTE_LAST) begin
        pix_hold[pix_phase[0]] = b;
        pix_phase++;
      end else begin
        px.chan_first  = pix_hold[0];
        px.chan_second = pix_hold[1];
        px.chan_third  = b;
        px.row_last    = 1'b0;
        px.image_last  = 1'b0;
        pix_phase = '0;
        col_cnt++;
        if (col_cnt == img_w) begin
          px.row_last = 1'b1;
          col_cnt = '0;
          row_cnt++;
          if (row_cnt == img_h) begin
            px.image_last = 1'b1;
            img_done = 1'b1;
          end else begin
            pad_cnt = img_w[1:0];
          end
        end
        pixel_queue.push_back(px);
      end
    end
    if (file_pos != '1) file_pos++;
  endtask

  task automatic check_pixel(input pix_item_t got);
    pix_item_t want;
    if (pixel_queue.size() == 0) begin
      fail_count++;
      if (fail_count <= MaxReports) begin
        $display("%0t: pixel with none pending: %h %h %h row_last %b image_last %b", $realtime,
                 got.chan_first, got.chan_second, got.chan_third, got.row_last,
                 got.image_last);
      end
    end else begin
      want = pixel_queue.pop_front();
      if (got.chan_first !== want.chan_first || got.chan_second !== want.chan_second ||
          got.chan_third !== want.chan_third || got.row_last !== want.row_last ||
          got.image_last !== want.image_last) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%0t: pixel mismatch: want %h %h %h rl %b il %b, got %h %h %h rl %b il %b",
                   $realtime, want.chan_first, want.chan_second, want.chan_third,
                   want.row_last, want.image_last, got.chan_first, got.chan_second,
                   got.chan_third, got.row_last, got.image_last);
        end
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pixels_due = 0;
    clear_frame();
  end

  // output side first: a pixel never leaves in the cycle of its own last byte
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      pixel_queue.delete();
    end else begin
      if (pixels.valid && pixels.ready) begin
        check_pixel('{pixels.chan_first, pixels.chan_second, pixels.chan_third,
                      pixels.row_last, pixels.image_last});
      end
      if (bytes.valid && bytes.ready) absorb_byte(bytes.byte_value, bytes.file_start);
    end
    pixels_due = pixel_queue.size();
  end

endmodule

// ===== verif/tb.sv =====
// testbench top for the bitmap deframer: file byte stimulus, pixel back-pressure, verdict
`timescale 1ns / 100ps
module tb;
  import bmpd_pkg::*;

  localparam int unsigned ItemTarget  = 1600;
  localparam int unsigned CalmTail    = 200;
  localparam int unsigned HoldAt      = 400;
  localparam int unsigned HoldLen     = 200;
  localparam int unsigned DrainCycles = 20;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pixels_due;
  int unsigned sent;
  int unsigned idle_pct;
  bit          calm;

  bmpd_byte_if bytes ();
  bmpd_pix_if  pixels ();

  bmp24_pixel_deframer_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .pixels (pixels)
  );

  bmpd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .pixels     (pixels),
    .fail_count (fail_count),
    .pixels_due (pixels_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // bytes after the header that a well-formed image needs
  function automatic int unsigned image_bytes(input int unsigned offs, input int unsigned w,
                                              input int unsigned h);
    int unsigned start;
    start = (offs > 26) ? offs : 26;
    return start - 26 + h * (3 * w + w % 4) - w % 4;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic mark);
    int unsigned gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 10);
      bytes.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes.valid      <= 1'b1;
    bytes.byte_value <= b;
    bytes.file_start <= mark;
    do @(posedge clk); while (!bytes.ready);
    sent++;
    if (sent >= ItemTarget - CalmTail) calm = 1'b1;
  endtask

  task automatic send_file(input logic mark, input logic [31:0] offs, input logic [31:0] w,
                           input logic [31:0] h, input int unsigned body_len);
    int unsigned k;
    logic [7:0]  val;
    for (k = 0; k < 26 + body_len; k++) begin
      val = 8'($urandom);
      if (k >= 10 && k < 14) val = offs[8*(k-10) +: 8];
      else if (k >= 18 && k < 22) val = w[8*(k-18) +: 8];
      else if (k >= 22 && k < 26) val = h[8*(k-22) +: 8];
      push_byte(val, mark && k == 0);
    end
  endtask

  // pixel receiver: short random stalls plus one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned stall_left;
    cyc = 0;
    stall_left = 0;
    pixels.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == HoldAt) stall_left = HoldLen;
      else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 10);
      if (stall_left != 0) begin
        pixels.ready <= 1'b0;
        stall_left--;
      end else begin
        pixels.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned body;
    logic [31:0] offs;
    logic [31:0] w;
    logic [31:0] h;
    logic        mark;
    rst = 1'b1;
    bytes.valid = 1'b0;
    bytes.byte_value = '0;
    bytes.file_start = 1'b0;
    sent = 0;
    idle_pct = 0;
    calm = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // no start mark after reset, offset inside the header, one pad byte per row,
    // then bytes past the image that must be ignored
    send_file(1'b0, 32'd0, 32'd1, 32'd2, image_bytes(0, 1, 2) + 2);

    while (sent < ItemTarget) begin
      kind = $urandom_range(0, 99);
      mark = ($urandom_range(0, 19) != 0);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      case ($urandom_range(0, 3))
        0:       offs = 26;
        1:       offs = 54;
        2:       offs = 26 + $urandom_range(1, 12);
        default: offs = $urandom_range(0, 25);
      endcase
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      h = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      body = image_bytes(offs, w, h);
      if (kind < 65) begin
        body = body + $urandom_range(0, 4);
      end else if (kind < 78) begin
        body = $urandom_range(0, body - 1);
      end else if (kind < 86) begin
        if ($urandom_range(0, 1) == 0) w = '0;
        else h = '0;
        body = $urandom_range(0, 24);
      end else if (kind < 94) begin
        case ($urandom_range(0, 2))
          0:       w = '1;
          1:       h = {1'b1, 31'($urandom)};
          default: offs = '1;
        endcase
        body = $urandom_range(12, 60);
      end else begin
        offs = $urandom;
        w = $urandom;
        h = $urandom;
        body = $urandom_range(0, 40);
      end
      send_file(mark, offs, w, h, body);
    end

    @(negedge clk);
    bytes.valid <= 1'b0;
    while (pixels_due != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
